[design/bbtl_pkg.sv]
package bbtl_pkg;

    // request kinds carried in the low bits of the input word
    typedef enum logic [1:0] {
        FN_GET     = 2'd0,
        FN_RELEASE = 2'd1,
        FN_PIN     = 2'd2,
        FN_UNPIN   = 2'd3
    } func_t;

    // result status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_ZERO = 2'd2;

    // reference count saturates here
    localparam logic [7:0] CNT_MAX = 8'hFF;

    // field widths of the words
    localparam int unsigned SLOT_W = 5;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_SLOT_RD,
        S_COMMIT
    } state_t;

    // one pool entry as held in the tag memory
    typedef struct packed {
        logic        used;
        logic [7:0]  dev;
        logic [31:0] blk;
        logic [7:0]  cnt;
        logic [31:0] stamp;
    } entry_t;

endpackage

[design/block_buffer_tag_lru.sv]
// Tag manager for a pool of ENTRIES disk-block buffers. A get request (func 0)
// walks the whole tag memory through its single read port, one entry per
// cycle, looking for the lowest-index entry tagged with the requested device
// and block and, alongside, for the unreferenced entry with the oldest stamp
// (ties to the lowest index). A hit bumps the count and restamps the entry; a
// miss retags the chosen victim with count 1 and reports hit = 0 so that a
// disk read can be started; status 1 means every entry is referenced.
// Release, pin and unpin (func 1..3) read and rewrite the one entry named by
// buffer_slot; status 2 flags a decrement of a zero count. A get passes
// through the scan, a drain step and the commit step before the next word
// can be accepted; release, pin and unpin pass through a slot read and the
// commit step, or go straight to commit when buffer_slot lies outside the
// pool. The commit step waits until the output register is free, that is
// until the previous result is taken. The result sits in an output
// register, so a new word is accepted while the previous result still
// waits. Per-entry valid bits make never-written entries read as zero, so
// no clearing pass runs after reset.
module block_buffer_tag_lru
    import bbtl_pkg::*;
#(
    parameter int unsigned ENTRIES = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [1:0] func, [9:2] device_id, [41:10] block_number,
    // [46:42] buffer_slot, [78:47] tick_now, [79] zero
    input  logic [79:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [4:0] slot_out, [5] hit, [7:6] status
    output logic [7:0]  m_tdata
);

    localparam int unsigned IW = $clog2(ENTRIES);
    localparam logic [8:0]  ENTRIES_W = 9'(ENTRIES);
    localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

    // request registers
    func_t        req_func_reg, req_func_next;
    logic [7:0]   req_dev_reg, req_dev_next;
    logic [31:0]  req_blk_reg, req_blk_next;
    logic [4:0]   req_slot_reg, req_slot_next;
    logic [31:0]  req_tick_reg, req_tick_next;

    // sequencer and scan state
    state_t        state_reg, state_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic          cmp_valid_reg, cmp_valid_next;
    logic [IW-1:0] cmp_idx_reg, cmp_idx_next;
    logic          hit_found_reg, hit_found_next;
    logic [IW-1:0] hit_idx_reg, hit_idx_next;
    logic [7:0]    hit_cnt_reg, hit_cnt_next;
    logic          vic_found_reg, vic_found_next;
    logic [IW-1:0] vic_idx_reg, vic_idx_next;
    logic [31:0]   oldest_reg, oldest_next;

    // result register
    logic          m_valid_reg, m_valid_next;
    logic [4:0]    m_slot_reg, m_slot_next;
    logic          m_hit_reg, m_hit_next;
    logic [1:0]    m_status_reg, m_status_next;

    // tag memory and its valid bits
    entry_t          mem [ENTRIES];
    logic [ENTRIES-1:0] valid_reg;
    entry_t          rd_data_reg;
    logic            rd_valid_reg;
    logic            rd_en;
    logic [IW-1:0]   rd_addr;
    logic            wr_en;
    logic [IW-1:0]   wr_addr;
    entry_t          wr_data;

    entry_t          rd_entry;
    logic            tag_match;
    logic            slot_in_range;
    logic [IW-1:0]   slot_idx;
    logic [IW+4:0]   slot_wide;
    logic            out_free;

    // widen an entry index to the five-bit slot field
    function automatic logic [4:0] idx_to_slot(input logic [IW-1:0] idx);
        logic [IW+4:0] wide;
        wide = {5'b0, idx};
        return wide[4:0];
    endfunction

    function automatic logic [7:0] sat_inc(input logic [7:0] cnt);
        return (cnt == CNT_MAX) ? cnt : cnt + 8'd1;
    endfunction

    // never-written entries read as all zero
    assign rd_entry  = rd_valid_reg ? rd_data_reg : '0;
    assign tag_match = rd_entry.used && (rd_entry.dev == req_dev_reg) &&
                       (rd_entry.blk == req_blk_reg);

    assign slot_in_range = ({4'b0, req_slot_reg} < ENTRIES_W);
    assign slot_wide     = {{IW{1'b0}}, req_slot_reg};
    assign slot_idx      = slot_wide[IW-1:0];

    assign out_free = !m_valid_reg || m_tready;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_status_reg, m_hit_reg, m_slot_reg};

    // sequencer: next state, scan bookkeeping, memory control and result
    always_comb begin
        state_next     = state_reg;
        req_func_next  = req_func_reg;
        req_dev_next   = req_dev_reg;
        req_blk_next   = req_blk_reg;
        req_slot_next  = req_slot_reg;
        req_tick_next  = req_tick_reg;
        idx_next       = idx_reg;
        cmp_valid_next = 1'b0;
        cmp_idx_next   = cmp_idx_reg;
        hit_found_next = hit_found_reg;
        hit_idx_next   = hit_idx_reg;
        hit_cnt_next   = hit_cnt_reg;
        vic_found_next = vic_found_reg;
        vic_idx_next   = vic_idx_reg;
        oldest_next    = oldest_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        m_slot_next    = m_slot_reg;
        m_hit_next     = m_hit_reg;
        m_status_next  = m_status_reg;
        rd_en          = 1'b0;
        rd_addr        = idx_reg;
        wr_en          = 1'b0;
        wr_addr        = slot_idx;
        wr_data        = rd_entry;

        // compare the entry read in the previous cycle
        if (cmp_valid_reg) begin
            if (!hit_found_reg && tag_match) begin
                hit_found_next = 1'b1;
                hit_idx_next   = cmp_idx_reg;
                hit_cnt_next   = rd_entry.cnt;
            end
            if ((rd_entry.cnt == 8'd0) &&
                (!vic_found_reg || (rd_entry.stamp < oldest_reg))) begin
                vic_found_next = 1'b1;
                vic_idx_next   = cmp_idx_reg;
                oldest_next    = rd_entry.stamp;
            end
        end

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    req_func_next  = func_t'(s_tdata[1:0]);
                    req_dev_next   = s_tdata[9:2];
                    req_blk_next   = s_tdata[41:10];
                    req_slot_next  = s_tdata[46:42];
                    req_tick_next  = s_tdata[78:47];
                    idx_next       = '0;
                    hit_found_next = 1'b0;
                    vic_found_next = 1'b0;
                    if (func_t'(s_tdata[1:0]) == FN_GET) begin
                        state_next = S_SCAN;
                    end else if ({4'b0, s_tdata[46:42]} < ENTRIES_W) begin
                        state_next = S_SLOT_RD;
                    end else begin
                        state_next = S_COMMIT;
                    end
                end
            end
            S_SCAN: begin
                // read one entry per cycle
                rd_en          = 1'b1;
                rd_addr        = idx_reg;
                cmp_valid_next = 1'b1;
                cmp_idx_next   = idx_reg;
                idx_next       = idx_reg + IW'(1);
                if (idx_reg == LAST_IDX) begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: begin
                state_next = S_COMMIT;
            end
            S_SLOT_RD: begin
                rd_en      = 1'b1;
                rd_addr    = slot_idx;
                state_next = S_COMMIT;
            end
            S_COMMIT: begin
                // hold until the output register is free
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_hit_next    = 1'b0;
                    m_status_next = ST_OK;
                    m_slot_next   = req_slot_reg;
                    state_next    = S_IDLE;
                    if (req_func_reg == FN_GET) begin
                        wr_data.used  = 1'b1;
                        wr_data.dev   = req_dev_reg;
                        wr_data.blk   = req_blk_reg;
                        wr_data.stamp = req_tick_reg;
                        if (hit_found_reg) begin
                            wr_en       = 1'b1;
                            wr_addr     = hit_idx_reg;
                            wr_data.cnt = sat_inc(hit_cnt_reg);
                            m_hit_next  = 1'b1;
                            m_slot_next = idx_to_slot(hit_idx_reg);
                        end else if (vic_found_reg) begin
                            wr_en       = 1'b1;
                            wr_addr     = vic_idx_reg;
                            wr_data.cnt = 8'd1;
                            m_slot_next = idx_to_slot(vic_idx_reg);
                        end else begin
                            m_status_next = ST_FULL;
                            m_slot_next   = 5'd0;
                        end
                    end else if (slot_in_range) begin
                        wr_addr = slot_idx;
                        if (req_func_reg == FN_PIN) begin
                            wr_en       = 1'b1;
                            wr_data.cnt = sat_inc(rd_entry.cnt);
                        end else if (rd_entry.cnt == 8'd0) begin
                            m_status_next = ST_ZERO;
                        end else begin
                            wr_en       = 1'b1;
                            wr_data.cnt = rd_entry.cnt - 8'd1;
                            if (req_func_reg == FN_RELEASE && rd_entry.cnt == 8'd1) begin
                                wr_data.stamp = req_tick_reg;
                            end
                        end
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state register and control flops
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            cmp_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
            valid_reg     <= '0;
        end else begin
            state_reg     <= state_next;
            cmp_valid_reg <= cmp_valid_next;
            m_valid_reg   <= m_valid_next;
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        req_func_reg  <= req_func_next;
        req_dev_reg   <= req_dev_next;
        req_blk_reg   <= req_blk_next;
        req_slot_reg  <= req_slot_next;
        req_tick_reg  <= req_tick_next;
        idx_reg       <= idx_next;
        cmp_idx_reg   <= cmp_idx_next;
        hit_found_reg <= hit_found_next;
        hit_idx_reg   <= hit_idx_next;
        hit_cnt_reg   <= hit_cnt_next;
        vic_found_reg <= vic_found_next;
        vic_idx_reg   <= vic_idx_next;
        oldest_reg    <= oldest_next;
        m_slot_reg    <= m_slot_next;
        m_hit_reg     <= m_hit_next;
        m_status_reg  <= m_status_next;
    end

    // tag memory: one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg  <= mem[rd_addr];
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    // a new result is only ever loaded from the commit step
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == S_COMMIT))
        else $error("result loaded outside commit");

    // memory is written only when the result is produced
    assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |=> m_valid_reg)
        else $error("memory write without a result");

    // a hit always reports ok
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_hit_reg) |-> (m_status_reg == ST_OK))
        else $error("hit with error status");

    // a full pool reports slot zero and no hit
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_status_reg == ST_FULL) |-> (m_slot_reg == 5'd0 && !m_hit_reg))
        else $error("full pool result malformed");

    // one word at a time: not ready right after acceptance
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("accepted a word while busy");

endmodule

[verif/testbench.sv]
`timescale 1ns / 100ps

module testbench;
    import bbtl_pkg::*;

    localparam int ENTRIES        = 32;
    localparam int RESET_CYCLES   = 9;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SHOWN_ERRORS   = 10;

    // expected content of one result word, slot in the low bits
    typedef struct packed {
        logic [1:0]        status;
        logic              hit;
        logic [SLOT_W-1:0] slot;
    } grant_t;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // [1:0] func, [9:2] device_id, [41:10] block_number,
    // [46:42] buffer_slot, [78:47] tick_now, [79] zero
    logic [79:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // [4:0] slot_out, [5] hit, [7:6] status
    logic [7:0]  m_tdata;

    // shadow copy of the tag memory and the grants still to come out
    entry_t      pool_shadow [ENTRIES];
    grant_t      grants_due [$];
    logic [4:0]  held_slots [$];
    logic [7:0]  wset_dev [8];
    logic [31:0] wset_blk [8];
    logic [31:0] tick_last = '0;

    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int unsigned words_sent    = 0;
    int unsigned results_seen  = 0;
    int unsigned mismatches    = 0;
    int unsigned gets_sent     = 0;
    int unsigned hits_sent     = 0;
    int unsigned full_sent     = 0;
    int unsigned refused_sent  = 0;

    block_buffer_tag_lru #(
        .ENTRIES (ENTRIES)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // stall the result side at the current rate
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= rx_stall_pct);
    end

    // work out the grant for one request and update the shadow pool
    function automatic grant_t buffer_grant(input func_t f, input logic [7:0] dev,
                                            input logic [31:0] blk, input logic [4:0] slot,
                                            input logic [31:0] tick);
        grant_t      g;
        bit          found;
        int          victim;
        logic [31:0] oldest;
        g      = '0;
        found  = 1'b0;
        victim = 0;
        oldest = '0;
        if (f == FN_GET) begin
            // lowest-index tag match counts as the hit
            for (int i = 0; i < ENTRIES; i++) begin
                if (pool_shadow[i].used && pool_shadow[i].dev == dev &&
                    pool_shadow[i].blk == blk) begin
                    if (pool_shadow[i].cnt != CNT_MAX)
                        pool_shadow[i].cnt = pool_shadow[i].cnt + 8'd1;
                    pool_shadow[i].stamp = tick;
                    g.slot   = SLOT_W'(i);
                    g.hit    = 1'b1;
                    g.status = ST_OK;
                    return g;
                end
            end
            // oldest unreferenced entry, ties to the lowest index
            for (int i = 0; i < ENTRIES; i++) begin
                if (pool_shadow[i].cnt == 8'd0 && (!found || pool_shadow[i].stamp < oldest)) begin
                    found  = 1'b1;
                    victim = i;
                    oldest = pool_shadow[i].stamp;
                end
            end
            if (!found) begin
                g.status = ST_FULL;
                return g;
            end
            pool_shadow[victim].used  = 1'b1;
            pool_shadow[victim].dev   = dev;
            pool_shadow[victim].blk   = blk;
            pool_shadow[victim].cnt   = 8'd1;
            pool_shadow[victim].stamp = tick;
            g.slot   = SLOT_W'(victim);
            g.status = ST_OK;
            return g;
        end
        g.slot = slot;
        if (f == FN_PIN) begin
            if (pool_shadow[slot].cnt != CNT_MAX)
                pool_shadow[slot].cnt = pool_shadow[slot].cnt + 8'd1;
            g.status = ST_OK;
            return g;
        end
        // release or unpin
        if (pool_shadow[slot].cnt == 8'd0) begin
            g.status = ST_ZERO;
            return g;
        end
        pool_shadow[slot].cnt = pool_shadow[slot].cnt - 8'd1;
        if (f == FN_RELEASE && pool_shadow[slot].cnt == 8'd0)
            pool_shadow[slot].stamp = tick;
        g.status = ST_OK;
        return g;
    endfunction

    // mostly rising ticks, with extremes and repeats to force stamp ties
    function automatic logic [31:0] next_tick();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 4)
            tick_last = '0;
        else if (r < 8)
            tick_last = '1;
        else if (r < 22)
            tick_last = $urandom;
        else if (r >= 30)
            tick_last = tick_last + $urandom_range(1, 500);
        return tick_last;
    endfunction

    task automatic note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= SHOWN_ERRORS)
            $display("MISMATCH: %s", msg);
    endtask

    // offer one request word, hold it until taken, then predict its grant
    task automatic send_word(input func_t f, input logic [7:0] dev, input logic [31:0] blk,
                             input logic [4:0] slot, input logic [31:0] tick,
                             output grant_t g);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, tick, slot, blk, dev, f};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        g = buffer_grant(f, dev, blk, slot, tick);
        grants_due.push_back(g);
        words_sent++;
        if (f == FN_GET) gets_sent++;
        if (g.hit) hits_sent++;
        if (g.status == ST_FULL) full_sent++;
        if (g.status == ST_ZERO) refused_sent++;
    endtask

    // compare every result word with the oldest grant due
    always @(posedge aclk) begin : result_check
        grant_t got;
        grant_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            results_seen++;
            if (grants_due.size() == 0) begin
                note_mismatch($sformatf("result word %h with no request pending", m_tdata));
            end else begin
                want = grants_due.pop_front();
                if (got.slot !== want.slot || got.hit !== want.hit ||
                    got.status !== want.status)
                    note_mismatch($sformatf(
                        {"result %0d: expected slot %0d hit %0d status %0d, ",
                         "got slot %0d hit %0d status %0d"},
                        results_seen, want.slot, want.hit, want.status,
                        got.slot, got.hit, got.status));
            end
        end
    end

    // end the run when no word moves for too long
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
        $display("block_buffer_tag_lru test failed");
        $finish;
    end

    task automatic test_directed_cases();
        grant_t g;
        // untouched pool: all stamps zero, so the first miss takes entry 0
        send_word(FN_GET, 8'h00, 32'h0000_0000, 5'd0, 32'h0000_0000, g);
        // hit on the same tag with the largest tick
        send_word(FN_GET, 8'h00, 32'h0000_0000, 5'd31, 32'hFFFF_FFFF, g);
        // extreme tag values miss and take the next entry
        send_word(FN_GET, 8'hFF, 32'hFFFF_FFFF, 5'd31, 32'hFFFF_FFFF, g);
        // release to zero stamps the entry, further decrements are refused
        send_word(FN_RELEASE, 8'hFF, 32'hFFFF_FFFF, 5'd1, 32'd7, g);
        send_word(FN_UNPIN, 8'h00, 32'h0000_0000, 5'd1, 32'd9, g);
        send_word(FN_RELEASE, 8'h5A, 32'h1234_5678, 5'd1, 32'd9, g);
        // count operations on an entry that was never tagged
        send_word(FN_RELEASE, 8'h00, 32'h0000_0000, 5'd31, 32'd1, g);
        send_word(FN_PIN, 8'hFF, 32'hFFFF_FFFF, 5'd31, 32'd2, g);
        send_word(FN_PIN, 8'h00, 32'h0000_0000, 5'd31, 32'd2, g);
        send_word(FN_UNPIN, 8'h00, 32'h0000_0000, 5'd31, 32'd3, g);
        send_word(FN_RELEASE, 8'h00, 32'h0000_0000, 5'd31, 32'd3, g);
        // unreferenced but still tagged: a get hits it again
        send_word(FN_GET, 8'hFF, 32'hFFFF_FFFF, 5'd0, 32'd11, g);
        // entry 0 drops to zero with the largest stamp, unpin leaves the stamp
        send_word(FN_RELEASE, 8'h00, 32'h0000_0000, 5'd0, 32'hFFFF_FFFF, g);
        send_word(FN_UNPIN, 8'h00, 32'h0000_0000, 5'd0, 32'd12, g);
        // misses go to the oldest free entries; tags differing in one field only
        send_word(FN_GET, 8'hA5, 32'h5A5A_A5A5, 5'd0, 32'd20, g);
        send_word(FN_GET, 8'h00, 32'h0000_0001, 5'd0, 32'd21, g);
        send_word(FN_GET, 8'h01, 32'h0000_0000, 5'd0, 32'd22, g);
        // hand everything back
        send_word(FN_RELEASE, 8'h00, 32'h0000_0000, 5'd1, 32'd30, g);
        send_word(FN_RELEASE, 8'h00, 32'h0000_0000, 5'd2, 32'd30, g);
        send_word(FN_RELEASE, 8'h00, 32'h0000_0000, 5'd3, 32'd31, g);
        send_word(FN_RELEASE, 8'h00, 32'h0000_0000, 5'd4, 32'd32, g);
        send_word(FN_UNPIN, 8'h00, 32'h0000_0000, 5'd0, 32'd33, g);
    endtask

    task automatic test_pool_exhaustion();
        grant_t      g;
        int          idx;
        logic [4:0]  s;
        logic [31:0] drain_tick;
        bit          same_stamp;
        // fill with fresh tags until every entry is referenced
        g = '0;
        for (int n = 0; n < 2 * ENTRIES && g.status != ST_FULL; n++) begin
            send_word(FN_GET, 8'($urandom), $urandom, 5'($urandom), next_tick(), g);
            if (g.status == ST_OK) held_slots.push_back(g.slot);
        end
        // further gets find no free entry
        repeat ($urandom_range(1, 3)) send_word(FN_GET, 8'($urandom), $urandom,
                                                5'($urandom), next_tick(), g);
        // free one entry with the largest stamp, it must still be chosen
        if (held_slots.size() != 0) begin
            idx = $urandom_range(held_slots.size() - 1);
            s   = held_slots[idx];
            held_slots.delete(idx);
            send_word(FN_RELEASE, 8'($urandom), $urandom, s, 32'hFFFF_FFFF, g);
        end
        send_word(FN_GET, 8'($urandom), $urandom, 5'($urandom), next_tick(), g);
        if (g.status == ST_OK) held_slots.push_back(g.slot);
        // drain in random order, sometimes all with one stamp
        same_stamp = 1'($urandom_range(1));
        drain_tick = next_tick();
        while (held_slots.size() != 0) begin
            idx = $urandom_range(held_slots.size() - 1);
            s   = held_slots[idx];
            held_slots.delete(idx);
            send_word(FN_RELEASE, 8'($urandom), $urandom, s,
                      same_stamp ? drain_tick : next_tick(), g);
        end
    endtask

    task automatic test_mixed_traffic(input int tx_pct, input int rx_pct, input int n_words);
        grant_t      g;
        int          idx;
        int          k;
        int          m;
        int          pick;
        int unsigned stop_at;
        logic [4:0]  s;
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        for (int i = 0; i < 8; i++) begin
            wset_dev[i] = 8'($urandom);
            wset_blk[i] = $urandom;
        end
        stop_at = words_sent + n_words;
        while (words_sent < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 40) begin
                // small working set: gets that mostly hit, releases of what was taken
                repeat ($urandom_range(8, 24)) begin
                    if (held_slots.size() != 0 && $urandom_range(99) < 45) begin
                        idx = $urandom_range(held_slots.size() - 1);
                        s   = held_slots[idx];
                        held_slots.delete(idx);
                        send_word(FN_RELEASE, 8'($urandom), $urandom, s, next_tick(), g);
                    end else begin
                        k = $urandom_range(7);
                        send_word(FN_GET, wset_dev[k], wset_blk[k], 5'($urandom),
                                  next_tick(), g);
                        if (g.status == ST_OK) held_slots.push_back(g.slot);
                    end
                end
            end else if (pick < 55) begin
                test_pool_exhaustion();
            end else if (pick < 70) begin
                // pin an entry a few times, then unpin as often again or once more
                s = 5'($urandom_range(ENTRIES - 1));
                m = $urandom_range(1, 6);
                repeat (m) send_word(FN_PIN, 8'($urandom), $urandom, s, next_tick(), g);
                repeat (m + $urandom_range(1))
                    send_word(FN_UNPIN, 8'($urandom), $urandom, s, next_tick(), g);
            end else begin
                // noise: any request with random fields
                repeat ($urandom_range(1, 8))
                    send_word(func_t'(2'($urandom_range(3))), 8'($urandom), $urandom,
                              5'($urandom), next_tick(), g);
            end
        end
        // return every reference before the next phase
        for (int i = 0; i < ENTRIES; i++) begin
            while (pool_shadow[i].cnt != 8'd0)
                send_word(FN_RELEASE, 8'($urandom), $urandom, SLOT_W'(i), next_tick(), g);
        end
        held_slots.delete();
    endtask

    task automatic test_count_saturation();
        grant_t     g;
        logic [4:0] s;
        // drive one count into saturation, then all the way back past zero
        s = 5'($urandom_range(ENTRIES - 1));
        repeat (int'(CNT_MAX) + 3)
            send_word(FN_PIN, 8'($urandom), $urandom, s, next_tick(), g);
        repeat (int'(CNT_MAX) + 2)
            send_word($urandom_range(1) ? FN_RELEASE : FN_UNPIN, 8'($urandom), $urandom, s,
                      next_tick(), g);
    endtask

    initial begin
        foreach (pool_shadow[i]) pool_shadow[i] = '0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        test_directed_cases();
        test_pool_exhaustion();
        test_mixed_traffic(0, 0, 380);
        test_mixed_traffic(48, 0, 360);
        test_mixed_traffic(0, 48, 360);
        test_mixed_traffic(22, 22, 300);
        test_count_saturation();

        // let the last results drain
        s_tvalid <= 1'b0;
        while (grants_due.size() != 0) @(posedge aclk);
        repeat (ENTRIES + 8) @(posedge aclk);

        $display("covered %0d request words: %0d gets (%0d hits, %0d with pool full), %0d %s",
                 words_sent, gets_sent, hits_sent, full_sent, refused_sent,
                 "refused decrements");
        $display("idle mixes none, sender, receiver and both; %0d results checked, %0d %s",
                 results_seen, mismatches, "mismatches");
        if (mismatches == 0) begin
            $display("block_buffer_tag_lru test passed");
        end else begin
            $display("block_buffer_tag_lru test failed");
        end
        $finish;
    end

endmodule
